// ----- design/dmrs_pkg.sv -----
`default_nettype none
package dmrs_pkg;

  localparam int TableRowsDefault = 7;
  localparam int TableRowsMax = 16;
  localparam int StepCount = 6;

  localparam logic [2:0] StepTop = 3'd5;
  localparam logic [2:0] StepReverseTop = 3'd3;
  localparam logic [2:0] StepOffCenter = 3'd4;
  localparam logic [7:0] HandKeyLevel = 8'd105;
  localparam logic [8:0] AutoRowBonus = 9'd12;
  localparam logic [2:0] AutoBonusRow = 3'd1;

  localparam logic [3:0] WaitPhase = 4'd2;
  localparam logic [3:0] WaitRamp = 4'd3;
  localparam logic [3:0] WaitStop = 4'd10;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_BRKOFF = 3'd1;
  localparam logic [2:0] PH_ACCEL = 3'd2;
  localparam logic [2:0] PH_RAMP = 3'd3;
  localparam logic [2:0] PH_STOP = 3'd4;
  localparam logic [2:0] PH_END = 3'd5;

  localparam logic [1:0] REG_TABLE_ROW = 2'd0;
  localparam logic [1:0] REG_IDLE_OFFSET = 2'd1;
  localparam logic [1:0] REG_AUTO_HIGH = 2'd2;
  localparam logic [1:0] REG_AUTO_LOW = 2'd3;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic [7:0] SPEED_TAB [TableRowsMax][StepCount] = '{
    '{8'd0, 8'd93, 8'd100, 8'd108, 8'd116, 8'd124},
    '{8'd1, 8'd94, 8'd109, 8'd124, 8'd139, 8'd152},
    '{8'd2, 8'd94, 8'd100, 8'd124, 8'd139, 8'd152},
    '{8'd3, 8'd98, 8'd110, 8'd124, 8'd139, 8'd152},
    '{8'd4, 8'd102, 8'd114, 8'd124, 8'd139, 8'd152},
    '{8'd5, 8'd105, 8'd118, 8'd124, 8'd139, 8'd152},
    '{8'd9, 8'd105, 8'd115, 8'd130, 8'd135, 8'd145},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0},
    '{default: 8'd0}
  };

  // Field order is highest bit first, so the low bits of tdata map directly.
  typedef struct packed {
    logic       auto_run;
    logic       auto_drive_key;
    logic       remote_drive_key;
    logic       local_drive_key;
    logic       hand_key_mode;
    logic       auto_high_speed;
    logic       auto_condition;
    logic       at_center;
    logic [2:0] speed_step;
    logic       start_forward;
  } item_t;

  typedef struct packed {
    logic [2:0] table_row;
    logic [6:0] idle_offset;
    logic [7:0] auto_high_level;
    logic [7:0] auto_low_level;
  } cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       motor_active;
    logic       brake_engaged;
    logic       forward_out;
    logic [7:0] dac_level;
  } result_t;

  function automatic logic [7:0] speed_level(input logic [3:0] row, input logic [2:0] col);
    return SPEED_TAB[row][col];
  endfunction

endpackage
`default_nettype wire

// ----- design/dmrs_target.sv -----
`default_nettype none
module dmrs_target #(
  parameter int TABLE_ROWS = dmrs_pkg::TableRowsDefault
) (
  input  wire dmrs_pkg::cfg_t  cfg,
  input  wire dmrs_pkg::item_t item,
  input  wire logic            direction,
  output logic [7:0]           target
);

  localparam logic [3:0] RowLast = 4'(TABLE_ROWS - 1);

  logic [3:0] row;
  logic [2:0] sp;
  logic [2:0] col;
  logic [8:0] lvl;

  always_comb begin
    row = ({1'b0, cfg.table_row} > RowLast) ? RowLast : {1'b0, cfg.table_row};
    sp = (item.speed_step > dmrs_pkg::StepTop) ? dmrs_pkg::StepTop : item.speed_step;
    col = sp;
    // off center drops the top two steps by one column
    if (!item.at_center && sp >= dmrs_pkg::StepOffCenter) begin
      col = sp - 3'd1;
    end
    // reverse caps the column and overrides the off-center rule
    if (!direction) begin
      col = (sp > dmrs_pkg::StepReverseTop) ? dmrs_pkg::StepReverseTop : sp;
    end
    lvl = 9'(dmrs_pkg::speed_level(row, col)) + 9'(cfg.idle_offset);
    if (item.auto_condition) begin
      lvl = 9'(item.auto_high_speed ? cfg.auto_high_level : cfg.auto_low_level)
          + ((cfg.table_row == dmrs_pkg::AutoBonusRow) ? dmrs_pkg::AutoRowBonus : 9'd0);
    end
    if (item.hand_key_mode) begin
      lvl = 9'(dmrs_pkg::HandKeyLevel);
    end
    target = lvl[8] ? 8'hFF : lvl[7:0];
  end

endmodule
`default_nettype wire

// ----- design/dmrs_seq.sv -----
`default_nettype none
module dmrs_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic             cmd,
  input  wire dmrs_pkg::item_t  item,
  input  wire logic [7:0]       new_target,
  output logic                  direction,
  output dmrs_pkg::result_t     result
);

  logic [2:0] seq_phase, seq_phase_next;
  logic [3:0] wait_count, wait_count_next;
  logic [7:0] target_level, target_level_next;
  logic [7:0] duty_level, duty_level_next;
  logic       active_flag, active_flag_next;
  logic       direction_flag, direction_flag_next;
  logic       brake_flag, brake_flag_next;
  logic       drive_key;

  assign direction = direction_flag;
  assign drive_key = item.local_drive_key || item.remote_drive_key
                     || (item.auto_run && item.auto_drive_key);

  always_comb begin
    seq_phase_next = seq_phase;
    wait_count_next = wait_count;
    target_level_next = target_level;
    duty_level_next = duty_level;
    active_flag_next = active_flag;
    direction_flag_next = direction_flag;
    brake_flag_next = brake_flag;
    if (cmd == dmrs_pkg::CMD_START) begin
      direction_flag_next = item.start_forward;
      active_flag_next = 1'b1;
      seq_phase_next = dmrs_pkg::PH_START;
      wait_count_next = 4'd0;
    end else begin
      if (wait_count != 4'd0) begin
        wait_count_next = wait_count - 4'd1;
      end
      if (active_flag) begin
        if (!drive_key && seq_phase != dmrs_pkg::PH_STOP) begin
          seq_phase_next = dmrs_pkg::PH_STOP;
          target_level_next = 8'd0;
          wait_count_next = dmrs_pkg::WaitStop;
        end
        if (wait_count_next == 4'd0) begin
          unique case (seq_phase_next)
            dmrs_pkg::PH_START: begin
              wait_count_next = dmrs_pkg::WaitPhase;
              seq_phase_next = dmrs_pkg::PH_BRKOFF;
            end
            dmrs_pkg::PH_BRKOFF: begin
              brake_flag_next = 1'b0;
              wait_count_next = dmrs_pkg::WaitPhase;
              seq_phase_next = dmrs_pkg::PH_ACCEL;
            end
            dmrs_pkg::PH_ACCEL: begin
              target_level_next = new_target;
              wait_count_next = dmrs_pkg::WaitPhase;
              seq_phase_next = dmrs_pkg::PH_RAMP;
            end
            dmrs_pkg::PH_RAMP: begin
              // step the duty level toward target; at target, go back to recompute it
              if (target_level_next == duty_level) begin
                seq_phase_next = dmrs_pkg::PH_ACCEL;
              end else if (target_level_next > duty_level) begin
                duty_level_next = duty_level + 8'd1;
              end else begin
                duty_level_next = duty_level - 8'd1;
              end
              wait_count_next = dmrs_pkg::WaitRamp;
            end
            dmrs_pkg::PH_STOP: begin
              if (duty_level != 8'd0) begin
                duty_level_next = duty_level - 8'd1;
                wait_count_next = dmrs_pkg::WaitStop;
              end else begin
                target_level_next = 8'd0;
                brake_flag_next = 1'b1;
                active_flag_next = 1'b0;
                seq_phase_next = dmrs_pkg::PH_END;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase <= dmrs_pkg::PH_END;
      wait_count <= 4'd0;
      target_level <= 8'd0;
      duty_level <= 8'd0;
      active_flag <= 1'b0;
      direction_flag <= 1'b1;
      brake_flag <= 1'b1;
    end else if (step) begin
      seq_phase <= seq_phase_next;
      wait_count <= wait_count_next;
      target_level <= target_level_next;
      duty_level <= duty_level_next;
      active_flag <= active_flag_next;
      direction_flag <= direction_flag_next;
      brake_flag <= brake_flag_next;
    end
  end

  always_comb begin
    result.dac_level = duty_level_next;
    result.forward_out = direction_flag_next;
    result.brake_engaged = brake_flag_next;
    result.motor_active = active_flag_next;
    result.phase = seq_phase_next;
  end

endmodule
`default_nettype wire

// ----- design/drive_motor_ramp_sequencer.sv -----
// Path: an input item is held in the input register, then its result is registered
// on m_tvalid/m_tdata once the result stage is free.
// Throughput: 1 item per cycle while m_tready is high; an input register and a result
// register frame the sequencer and target-lookup logic, and state updates as the result loads.
// Reset (rst, synchronous, active high): phase end, brake engaged, forward,
// level and target 0, registers 0, both stream stages empty.
`default_nettype none
module drive_motor_ramp_sequencer #(
  parameter int TABLE_ROWS = dmrs_pkg::TableRowsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [0] start_forward, [3:1] speed_step, [4] at_center, [5] auto_condition,
  // [6] auto_high_speed, [7] hand_key_mode, [8] local_drive_key,
  // [9] remote_drive_key, [10] auto_drive_key, [11] auto_run, [15:12] zero
  input  wire logic [15:0] s_tdata,
  // [0] cmd
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] dac_level, [8] forward_out, [9] brake_engaged, [10] motor_active,
  // [13:11] phase, [15:14] zero
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  dmrs_pkg::cfg_t    cfg;
  dmrs_pkg::item_t   in_item;
  dmrs_pkg::result_t result;
  logic              in_cmd;
  logic              in_valid;
  logic              out_free;
  logic              step;
  logic              direction;
  logic [7:0]        new_target;

  assign cfg_ready = 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign step = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dmrs_pkg::REG_TABLE_ROW: cfg.table_row <= cfg_data[2:0];
        dmrs_pkg::REG_IDLE_OFFSET: cfg.idle_offset <= cfg_data[6:0];
        dmrs_pkg::REG_AUTO_HIGH: cfg.auto_high_level <= cfg_data;
        dmrs_pkg::REG_AUTO_LOW: cfg.auto_low_level <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= dmrs_pkg::item_t'(s_tdata[11:0]);
      in_cmd <= s_tuser;
    end
  end

  dmrs_target #(
    .TABLE_ROWS(TABLE_ROWS)
  ) u_target (
    .cfg(cfg),
    .item(in_item),
    .direction(direction),
    .target(new_target)
  );

  dmrs_seq u_seq (
    .clk(clk),
    .rst(rst),
    .step(step),
    .cmd(in_cmd),
    .item(in_item),
    .new_target(new_target),
    .direction(direction),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {2'b00, result};
    end
  end

endmodule
`default_nettype wire

// ----- design/dmrs_checker.sv -----
`default_nettype none
module dmrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input side never blocks while the result stage is empty
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty result stage");

  // an idle motor sits in the end phase
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[10] |-> m_tdata[13:11] == dmrs_pkg::PH_END)
    else $error("inactive motor outside end phase");

  // brake is released only while the sequence runs
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[9] |-> m_tdata[10])
    else $error("brake released while inactive");

endmodule

bind drive_motor_ramp_sequencer dmrs_checker u_dmrs_checker (
  .clk(clk),
  .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
`default_nettype wire
